// ----- hw/rtl/lru_pkg.sv -----
package lru_pkg;

    localparam int ENTRIES_DEF   = 16;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CAP_BITS      = 5;
    localparam int PAGE_IN_BITS  = 16;
    localparam int EV_BITS       = 16;
    localparam int COUNT_BITS    = 32;
    localparam int TDATA_BITS    = EV_BITS + 2 * COUNT_BITS;
    localparam int TUSER_BITS    = 2;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_UPDATE = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    typedef struct packed {
        logic age_all;
        logic replace;
    } upd_ctl_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ----- hw/rtl/lru_ram.sv -----
module lru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lru_scan_unit.sv -----
module lru_scan_unit #(
    parameter int PAGE_BITS = 16,
    parameter int RANK_BITS = 4,
    parameter int CNT_BITS  = 5
) (
    input  logic [PAGE_BITS+RANK_BITS-1:0] entry_word,
    input  logic [RANK_BITS-1:0]           entry_idx,
    input  logic [PAGE_BITS-1:0]           req_page,
    input  logic [CNT_BITS-1:0]            filled,
    input  logic [RANK_BITS-1:0]           hit_rank,
    input  logic [RANK_BITS-1:0]           tgt_idx,
    input  lru_pkg::upd_ctl_t              ctl,
    output logic                           match,
    output logic                           is_lru,
    output logic [PAGE_BITS+RANK_BITS-1:0] new_word
);

    logic [PAGE_BITS-1:0] entry_page;
    logic [RANK_BITS-1:0] entry_rank;
    logic                 aged;

    assign entry_page = entry_word[PAGE_BITS+RANK_BITS-1:RANK_BITS];
    assign entry_rank = entry_word[RANK_BITS-1:0];

    assign match  = (entry_page == req_page);
    assign is_lru = ((CNT_BITS'(entry_rank) + 1'b1) == filled);
    assign aged   = ctl.age_all || (entry_rank < hit_rank);

    always_comb begin
        if (ctl.replace && (entry_idx == tgt_idx)) begin
            new_word = {req_page, {RANK_BITS{1'b0}}};
        end else if (aged) begin
            new_word = {entry_page, entry_rank + 1'b1};
        end else begin
            new_word = entry_word;
        end
    end

endmodule

// ----- hw/rtl/lru_page_replacement_unit.sv -----
// Each input beat is handled by two sweeps over the F filled entries of the single
// entry RAM (F is the fill level before the request, at most ENTRIES): one to search,
// one to age or replace the recency ranks; a miss that finds a free entry adds a fill
// step. A new beat is accepted only after the previous result is loaded for output.
// Reset (aresetn, synchronous, active low): fill level and counters clear,
// capacity returns to ENTRIES; the entry RAM needs no clearing pass.
module lru_page_replacement_unit #(
    parameter int ENTRIES   = lru_pkg::ENTRIES_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lru_pkg::CAP_BITS-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lru_pkg::PAGE_IN_BITS-1:0]  s_tdata,  // page
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lru_pkg::TDATA_BITS-1:0]    m_tdata,  // evicted_page, miss_count, request_count
    output logic [lru_pkg::TUSER_BITS-1:0]    m_tuser   // hit, evicted_valid
);

    localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS  = $clog2(ENTRIES + 1);
    localparam int CW        = (CNT_BITS > lru_pkg::CAP_BITS) ? CNT_BITS : lru_pkg::CAP_BITS;
    localparam int WORD_BITS = PAGE_BITS + RANK_BITS;
    localparam int CB        = lru_pkg::COUNT_BITS;

    lru_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]        cap_reg, cap_next;
    logic [CNT_BITS-1:0]  filled_reg, filled_next;
    logic [CB-1:0]        req_cnt_reg, req_cnt_next;
    logic [CB-1:0]        miss_cnt_reg, miss_cnt_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 rvalid_reg, rvalid_next;
    logic [RANK_BITS-1:0] ridx_reg, ridx_next;
    logic                 found_reg, found_next;
    logic [RANK_BITS-1:0] hit_idx_reg, hit_idx_next;
    logic [RANK_BITS-1:0] hit_rank_reg, hit_rank_next;
    logic [RANK_BITS-1:0] lru_idx_reg, lru_idx_next;
    logic [PAGE_BITS-1:0] lru_page_reg, lru_page_next;
    lru_pkg::upd_ctl_t    ctl_reg, ctl_next;
    logic [RANK_BITS-1:0] tgt_idx_reg, tgt_idx_next;
    logic                 fill_reg, fill_next;
    logic                 ev_valid_reg, ev_valid_next;
    logic [PAGE_BITS-1:0] ev_page_reg, ev_page_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic                 out_ev_valid_reg, out_ev_valid_next;
    logic [lru_pkg::EV_BITS-1:0] out_ev_page_reg, out_ev_page_next;
    logic [CB-1:0]        out_miss_reg, out_miss_next;
    logic [CB-1:0]        out_req_reg, out_req_next;

    logic                 ram_we;
    logic [RANK_BITS-1:0] ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 scan_match;
    logic                 scan_is_lru;
    logic [WORD_BITS-1:0] scan_word;
    logic [CW-1:0]        cap_eff;
    logic                 room;

    lru_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[RANK_BITS-1:0]),
        .rdata (ram_rdata)
    );

    lru_scan_unit #(
        .PAGE_BITS (PAGE_BITS),
        .RANK_BITS (RANK_BITS),
        .CNT_BITS  (CNT_BITS)
    ) u_scan (
        .entry_word (ram_rdata),
        .entry_idx  (ridx_reg),
        .req_page   (page_reg),
        .filled     (filled_reg),
        .hit_rank   (hit_rank_reg),
        .tgt_idx    (tgt_idx_reg),
        .ctl        (ctl_reg),
        .match      (scan_match),
        .is_lru     (scan_is_lru),
        .new_word   (scan_word)
    );

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CW'(1);
        end else if (cap_reg > CW'(ENTRIES)) begin
            cap_eff = CW'(ENTRIES);
        end else begin
            cap_eff = cap_reg;
        end
    end

    assign room = (CW'(filled_reg) < cap_eff);

    always_comb begin
        state_next        = state_reg;
        cap_next          = cap_reg;
        filled_next       = filled_reg;
        req_cnt_next      = req_cnt_reg;
        miss_cnt_next     = miss_cnt_reg;
        page_next         = page_reg;
        cnt_next          = cnt_reg;
        rvalid_next       = 1'b0;
        ridx_next         = ridx_reg;
        found_next        = found_reg;
        hit_idx_next      = hit_idx_reg;
        hit_rank_next     = hit_rank_reg;
        lru_idx_next      = lru_idx_reg;
        lru_page_next     = lru_page_reg;
        ctl_next          = ctl_reg;
        tgt_idx_next      = tgt_idx_reg;
        fill_next         = fill_reg;
        ev_valid_next     = ev_valid_reg;
        ev_page_next      = ev_page_reg;
        m_valid_next      = m_valid_reg;
        out_hit_next      = out_hit_reg;
        out_ev_valid_next = out_ev_valid_reg;
        out_ev_page_next  = out_ev_page_reg;
        out_miss_next     = out_miss_reg;
        out_req_next      = out_req_reg;
        ram_re            = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = ridx_reg;
        ram_wdata         = scan_word;

        if (cfg_wr_en) begin
            cap_next = CW'(cfg_wr_data);
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // compare the returning entry against the request
        if ((state_reg == lru_pkg::ST_SEARCH) && rvalid_reg) begin
            if (scan_match && !found_reg) begin
                found_next    = 1'b1;
                hit_idx_next  = ridx_reg;
                hit_rank_next = ram_rdata[RANK_BITS-1:0];
            end
            if (scan_is_lru) begin
                lru_idx_next  = ridx_reg;
                lru_page_next = ram_rdata[WORD_BITS-1:RANK_BITS];
            end
        end

        // write back the aged or replaced entry
        if ((state_reg == lru_pkg::ST_UPDATE) && rvalid_reg) begin
            ram_we = 1'b1;
        end

        case (state_reg)
            lru_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    page_next     = PAGE_BITS'(s_tdata);
                    req_cnt_next  = lru_pkg::sat_inc(req_cnt_reg);
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    hit_idx_next  = '0;
                    hit_rank_next = '0;
                    lru_idx_next  = '0;
                    lru_page_next = '0;
                    state_next    = lru_pkg::ST_SEARCH;
                end
            end
            lru_pkg::ST_SEARCH: begin
                if (cnt_reg < filled_reg) begin
                    ram_re      = 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = cnt_reg[RANK_BITS-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end else begin
                    state_next = lru_pkg::ST_DECIDE;
                end
            end
            lru_pkg::ST_DECIDE: begin
                ctl_next.age_all = !found_reg;
                ctl_next.replace = found_reg || !room;
                tgt_idx_next     = found_reg ? hit_idx_reg : lru_idx_reg;
                fill_next        = !found_reg && room;
                ev_valid_next    = !found_reg && !room;
                ev_page_next     = (!found_reg && !room) ? lru_page_reg : '0;
                if (!found_reg) begin
                    miss_cnt_next = lru_pkg::sat_inc(miss_cnt_reg);
                end
                cnt_next   = '0;
                state_next = lru_pkg::ST_UPDATE;
            end
            lru_pkg::ST_UPDATE: begin
                if (cnt_reg < filled_reg) begin
                    ram_re      = 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = cnt_reg[RANK_BITS-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end else begin
                    state_next = fill_reg ? lru_pkg::ST_FILL : lru_pkg::ST_DONE;
                end
            end
            lru_pkg::ST_FILL: begin
                ram_we      = 1'b1;
                ram_waddr   = filled_reg[RANK_BITS-1:0];
                ram_wdata   = {page_reg, {RANK_BITS{1'b0}}};
                filled_next = filled_reg + 1'b1;
                state_next  = lru_pkg::ST_DONE;
            end
            lru_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next      = 1'b1;
                    out_hit_next      = found_reg;
                    out_ev_valid_next = ev_valid_reg;
                    out_ev_page_next  = lru_pkg::EV_BITS'(ev_page_reg);
                    out_miss_next     = miss_cnt_reg;
                    out_req_next      = req_cnt_reg;
                    state_next        = lru_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lru_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lru_pkg::ST_IDLE;
            cap_reg      <= CW'(ENTRIES);
            filled_reg   <= '0;
            req_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            rvalid_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            filled_reg   <= filled_next;
            req_cnt_reg  <= req_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            rvalid_reg   <= rvalid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg         <= page_next;
        cnt_reg          <= cnt_next;
        ridx_reg         <= ridx_next;
        found_reg        <= found_next;
        hit_idx_reg      <= hit_idx_next;
        hit_rank_reg     <= hit_rank_next;
        lru_idx_reg      <= lru_idx_next;
        lru_page_reg     <= lru_page_next;
        ctl_reg          <= ctl_next;
        tgt_idx_reg      <= tgt_idx_next;
        fill_reg         <= fill_next;
        ev_valid_reg     <= ev_valid_next;
        ev_page_reg      <= ev_page_next;
        out_hit_reg      <= out_hit_next;
        out_ev_valid_reg <= out_ev_valid_next;
        out_ev_page_reg  <= out_ev_page_next;
        out_miss_reg     <= out_miss_next;
        out_req_reg      <= out_req_next;
    end

    assign s_tready = (state_reg == lru_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_req_reg, out_miss_reg, out_ev_page_reg};
    assign m_tuser  = {out_ev_valid_reg, out_hit_reg};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CNT_BITS'(ENTRIES))
        else $error("fill level above entry count");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_hit_reg && out_ev_valid_reg))
        else $error("hit reported together with eviction");

    a_miss_le_req: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_miss_reg <= out_req_reg))
        else $error("miss count above request count");

    a_req_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (req_cnt_reg != {CB{1'b1}}))
        |=> (req_cnt_reg == $past(req_cnt_reg) + 1'b1))
        else $error("request count did not advance");
`endif

endmodule
